// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/kp800_pkg.sv =====
// Shared types, constants and functions of the Keccak-p[800] sponge.
package kp800_pkg;
  localparam int CapacityHalfBytes = 16;
  localparam int Rounds = 22;
  localparam int TotalRounds = 22;
  localparam int RateBytes = 100 - 2 * CapacityHalfBytes;
  localparam int FirstRound = TotalRounds - Rounds;

  typedef logic [2:0] func_t;
  localparam func_t FUNC_RESTART = 3'd0;
  localparam func_t FUNC_ABSORB = 3'd1;
  localparam func_t FUNC_FINAL = 3'd2;
  localparam func_t FUNC_SQUEEZE = 3'd3;
  localparam func_t FUNC_XOR = 3'd4;

  typedef logic [31:0] lane_t;
  typedef lane_t [24:0] state_t;
  typedef logic [6:0] pos_t;
  typedef logic [4:0] rnd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic xor_data;
    logic xor_pad;
    logic round;
    logic zero_pos;
    logic adv_pos;
    logic load_out;
    logic xor_out;
    logic zero_out;
    logic hold_out;
    rnd_t rnd;
  } kp_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic full;
  } kp_stat_t;

  function automatic lane_t round_const(input rnd_t r);
    lane_t rc;
    case (r)
      5'd0: rc = 32'h00000001; 5'd1: rc = 32'h00008082;
      5'd2: rc = 32'h0000808A; 5'd3: rc = 32'h80008000;
      5'd4: rc = 32'h0000808B; 5'd5: rc = 32'h80000001;
      5'd6: rc = 32'h80008081; 5'd7: rc = 32'h00008009;
      5'd8: rc = 32'h0000008A; 5'd9: rc = 32'h00000088;
      5'd10: rc = 32'h80008009; 5'd11: rc = 32'h8000000A;
      5'd12: rc = 32'h8000808B; 5'd13: rc = 32'h0000008B;
      5'd14: rc = 32'h00008089; 5'd15: rc = 32'h00008003;
      5'd16: rc = 32'h00008002; 5'd17: rc = 32'h00000080;
      5'd18: rc = 32'h0000800A; 5'd19: rc = 32'h8000000A;
      5'd20: rc = 32'h80008081; 5'd21: rc = 32'h00008080;
      default: rc = 32'h0;
    endcase
    return rc;
  endfunction

  function automatic int rot_amt(input int i);
    int t [25] = '{0, 1, 30, 28, 27, 4, 12, 6, 23, 20, 3, 10, 11, 25, 7,
                   9, 13, 15, 21, 8, 18, 2, 29, 24, 14};
    return t[i];
  endfunction

  function automatic lane_t rol(input lane_t v, input int n);
    return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
  endfunction
endpackage

// ===== rtl/core/kp800_datapath.sv =====
// State register, one-round permutation unit, byte access and output register.
module kp800_datapath import kp800_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  kp_cmd_t  cmd,
  input  logic [7:0] data_byte,
  output kp_stat_t stat,
  output logic [7:0] out_byte
);
  state_t st, st_next, rnd_out;
  pos_t pos;
  logic [7:0] cur_byte, out_reg, out_hold;

  // One Keccak-p round applied to the current state.
  always_comb begin
    lane_t c [5];
    lane_t d [5];
    lane_t a [25];
    lane_t b [25];
    for (int x = 0; x < 5; x++)
      c[x] = st[x] ^ st[x+5] ^ st[x+10] ^ st[x+15] ^ st[x+20];
    for (int x = 0; x < 5; x++)
      d[x] = c[(x+4)%5] ^ rol(c[(x+1)%5], 1);
    for (int i = 0; i < 25; i++) a[i] = st[i] ^ d[i%5];
    for (int y = 0; y < 5; y++)
      for (int x = 0; x < 5; x++)
        b[y + 5*((2*x + 3*y)%5)] = rol(a[x+5*y], rot_amt(x+5*y));
    for (int y = 0; y < 5; y++)
      for (int x = 0; x < 5; x++)
        rnd_out[x+5*y] = b[x+5*y] ^ (~b[(x+1)%5+5*y] & b[(x+2)%5+5*y]);
    rnd_out[0] = rnd_out[0] ^ round_const(cmd.rnd);
  end

  // Byte at the current position; positions past the state read zero.
  always_comb begin
    cur_byte = '0;
    if (pos < 7'd100) cur_byte = st[pos[6:2]][8*pos[1:0] +: 8];
  end

  // Next state selection.
  always_comb begin
    st_next = st;
    if (cmd.round) st_next = rnd_out;
    if (cmd.xor_data && pos < 7'd100)
      st_next[pos[6:2]][8*pos[1:0] +: 8] = cur_byte ^ data_byte;
    if (cmd.xor_pad) begin
      if (pos < 7'd100)
        st_next[pos[6:2]][8*pos[1:0] +: 8] = cur_byte ^ 8'h1F;
      st_next[(RateBytes-1)/4][8*((RateBytes-1)%4) +: 8] =
        st_next[(RateBytes-1)/4][8*((RateBytes-1)%4) +: 8] ^ 8'h80;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      st <= '0;
      pos <= '0;
    end else begin
      st <= st_next;
      if (cmd.zero_pos) pos <= '0;
      else if (cmd.adv_pos) pos <= pos + 7'd1;
    end
    if (cmd.load_out) out_reg <= cmd.xor_out ? (cur_byte ^ data_byte) : cur_byte;
    else if (cmd.clear || cmd.xor_data || cmd.xor_pad || cmd.zero_out) out_reg <= '0;
  end

  // Output register, loaded when the result is presented and held until taken.
  always_ff @(posedge clk) begin
    if (cmd.hold_out) out_hold <= out_reg;
  end

  assign stat.full = (pos >= 7'(RateBytes));
  assign out_byte = out_hold;
endmodule

// ===== rtl/core/kp800_ctrl.sv =====
// Command sequencer: accepts transactions, steps permutation rounds, drives output valid.
module kp800_ctrl import kp800_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  func_t    func,
  output logic     out_valid,
  input  logic     out_ready,
  input  kp_stat_t stat,
  output kp_cmd_t  cmd
);
  typedef enum logic [2:0] {S_IDLE, S_PRE, S_OP, S_POST, S_DONE} st_t;
  st_t state;
  func_t op;
  rnd_t rnd;
  logic accept, last, emit;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign last = (rnd == 5'(TotalRounds - 1));

  // The result is presented once any permutation is done and the output register is free.
  assign emit = (state == S_DONE) && !(op == FUNC_ABSORB && stat.full) &&
                (!out_valid || out_ready);

  // Command decode per state.
  always_comb begin
    cmd = '0;
    cmd.rnd = rnd;
    unique case (state)
      S_PRE, S_POST: begin
        cmd.round = 1'b1;
        cmd.zero_pos = last;
      end
      S_OP: begin
        unique case (op)
          FUNC_RESTART: cmd.clear = 1'b1;
          FUNC_ABSORB: begin cmd.xor_data = 1'b1; cmd.adv_pos = 1'b1; end
          FUNC_FINAL: cmd.xor_pad = 1'b1;
          FUNC_SQUEEZE: begin cmd.load_out = 1'b1; cmd.adv_pos = 1'b1; end
          FUNC_XOR: begin
            cmd.load_out = 1'b1; cmd.xor_out = 1'b1; cmd.adv_pos = 1'b1;
          end
          default: cmd.zero_out = 1'b1;
        endcase
      end
      S_DONE: cmd.hold_out = emit;
      default: cmd.clear = 1'b0;
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      rnd <= '0;
      op <= FUNC_RESTART;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          op <= func;
          rnd <= 5'(FirstRound);
          if (stat.full && func != FUNC_RESTART && func <= FUNC_XOR) state <= S_PRE;
          else state <= S_OP;
        end
        S_PRE: begin
          rnd <= last ? 5'(FirstRound) : rnd + 5'd1;
          if (last) state <= S_OP;
        end
        S_OP: begin
          rnd <= 5'(FirstRound);
          if (op == FUNC_FINAL) state <= S_POST;
          else state <= S_DONE;
        end
        S_POST: begin
          rnd <= rnd + 5'd1;
          if (last) state <= S_DONE;
        end
        S_DONE: begin
          if (op == FUNC_ABSORB && stat.full) begin
            state <= S_POST;
            rnd <= 5'(FirstRound);
          end else if (emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/keccak_p800_sponge_xof_top.sv =====
// Top level of the byte-wide Keccak-p[800] sponge.
// One transaction in, one result out. A plain byte command is executed in the
// cycle after acceptance and its result is then presented through the output
// register; the next transaction can be accepted as soon as that result is
// presented, not before. A permutation runs one round per cycle through the
// single shared round unit, 22 rounds in all: finalize runs it after the
// padding, a command that finds the rate block full runs it first, and an
// absorb that fills the block runs it before presenting its result. The result
// sits in its own output register, so the next transaction is accepted while it
// waits; that transaction then holds its own result back until the previous
// one has been taken.
module keccak_p800_sponge_xof_top import kp800_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] func,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte
);
  kp_cmd_t cmd;
  kp_stat_t stat;
  logic [7:0] data_q;

  // Hold the data byte of the accepted transaction.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) data_q <= data_byte;
  end

  kp800_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .func(func_t'(func)),
    .out_valid, .out_ready, .stat, .cmd
  );

  kp800_datapath u_dp (
    .clk, .rst, .cmd, .data_byte(data_q), .stat, .out_byte
  );
endmodule

// ===== rtl/core/kp800_checker.sv =====
// Port-level checker for the sponge top level, with its bind.
`include "assert_macros.svh"
module kp800_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [7:0] out_byte
);
  `ASSERT_IMPLIES(a_known, clk, rst, out_valid, !$isunknown(out_byte))
  `ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte))
endmodule

bind keccak_p800_sponge_xof_top kp800_checker u_chk (.*);
